// ----- sv/fac_pkg.sv -----
// Shared types, constants and helper functions for the size class allocator.
// Used by every module in this folder but fac_ram; depends on nothing else.
package fac_pkg;

  localparam int SIZE_W          = 32;
  localparam int ADDR_BITS       = 48;
  localparam int CLASS_W         = 5;
  localparam int STATUS_W        = 3;
  localparam int MAXREG_W        = 26;
  localparam int NUM_CLASSES_DEF = 26;
  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [MAXREG_W-1:0] MAX_POOL_RESET = 26'd33554432;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BACK_ROUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BACK_OVER  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_KEPT       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NULL       = 3'd5;

  typedef struct packed {
    logic                 op;
    logic [SIZE_W-1:0]    size_bytes;
    logic [ADDR_BITS-1:0] block_addr;
  } fac_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ADDR_BITS-1:0] result_addr;
    logic [SIZE_W-1:0]    backing_size;
    logic [CLASS_W-1:0]   size_class;
  } fac_rsp_t;

  // Classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic                 is_free;
    logic                 null_addr;
    logic                 pooled;
    logic [CLASS_W-1:0]   cls;
    logic [SIZE_W-1:0]    size;
    logic [ADDR_BITS-1:0] addr;
  } fac_cmd_t;

  // Smallest k with 2^k >= s, for s of at least one. The top set bit of s-1
  // is found by a five-step binary search.
  function automatic logic [5:0] ceil_log2(logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] v;
    logic [5:0]        pos;
    v   = s - 32'd1;
    pos = 6'd0;
    if (s <= 32'd1) begin
      return 6'd0;
    end
    if (v[31:16] != 16'd0) begin
      pos = pos + 6'd16;
      v   = v >> 16;
    end
    if (v[15:8] != 8'd0) begin
      pos = pos + 6'd8;
      v   = v >> 8;
    end
    if (v[7:4] != 4'd0) begin
      pos = pos + 6'd4;
      v   = v >> 4;
    end
    if (v[3:2] != 2'd0) begin
      pos = pos + 6'd2;
      v   = v >> 2;
    end
    if (v[1]) begin
      pos = pos + 6'd1;
    end
    return pos + 6'd1;
  endfunction

endpackage

// ----- sv/size_class_free_list_allocator.sv -----
// Power-of-two size class allocator front end with bounded per-class stacks.
// A taken request is registered in the front register, then in a queue slot,
// then in the back end result registers with the stack RAM read, which drive
// the result strobe. The front end holds busy for one cycle while it classifies
// and queues each request, so a new request is taken only after the last is queued.
// Reset empties the stacks and queue and sets max_pool_bytes to 33554432; results never stall.
module size_class_free_list_allocator #(
  parameter int NUM_CLASSES = fac_pkg::NUM_CLASSES_DEF,
  parameter int STACK_DEPTH = fac_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  fac_pkg::fac_req_t            req,
  output logic                         done,
  output fac_pkg::fac_rsp_t            result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fac_pkg::MAXREG_W-1:0] cfg_data
);
  import fac_pkg::*;

  logic [MAXREG_W-1:0] max_pool_bytes;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  fac_cmd_t            q_in;
  fac_cmd_t            q_out;

  // The configuration channel is always ready; a transfer is registered into max_pool_bytes when taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pool_bytes <= MAX_POOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_pool_bytes <= cfg_data;
    end
  end

  // The front end registers each request, finds its size class and whether
  // the class stacks serve it, then queues the classified request.
  fac_front #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .req            (req),
    .max_pool_bytes (max_pool_bytes),
    .busy           (busy),
    .q_push         (q_push),
    .q_data         (q_in),
    .q_full         (q_full)
  );

  // The queue decouples classification from the stack updates.
  fac_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // The back end owns the fill counters and stack RAM. A fill counter changes
  // at the same edge as the RAM write, so the next item to the same class
  // sees both updates without any forwarding.
  fac_back #(
    .NUM_CLASSES (NUM_CLASSES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .done    (done),
    .result  (result)
  );

  // The front end never pushes into a full queue.
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("request queue overflow");

  // Every result strobe follows a queue transfer into the back end.
  a_done_from_pop : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(q_pop))
    else $error("result strobe without a dequeued request");

  // A taken request sets busy, which holds off the next one.
  a_busy_after_take : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after a request was taken");

  // A pool hit or a kept block always names a class inside the configured range.
  a_class_range : assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_HIT || result.status == ST_KEPT))
      |-> (32'(result.size_class) < NUM_CLASSES))
    else $error("size class out of range");

endmodule

// ----- sv/fac_ram.sv -----
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing; the contents have no reset.
module fac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/fac_front.sv -----
// Front end: takes a request, registers it, works out its size class and
// whether the class stacks serve it, and pushes the result into the queue.
// Depends on fac_pkg.
module fac_front #(
  parameter int NUM_CLASSES = fac_pkg::NUM_CLASSES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  fac_pkg::fac_req_t              req,
  input  logic [fac_pkg::MAXREG_W-1:0]   max_pool_bytes,
  output logic                           busy,
  output logic                           q_push,
  output fac_pkg::fac_cmd_t              q_data,
  input  logic                           q_full
);
  import fac_pkg::*;

  logic              held;
  fac_req_t          req_q;
  logic [SIZE_W-1:0] size_eff;
  logic [5:0]        k;
  logic              pooled;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (start && !busy) begin
      held <= 1'b1;
    end else if (q_push && !q_full) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
  end

  assign busy = held;

  always_comb begin
    size_eff = (req_q.size_bytes == '0) ? 32'd1 : req_q.size_bytes;
    k        = ceil_log2(size_eff);
    pooled   = (size_eff <= {6'd0, max_pool_bytes}) && (k < 6'(NUM_CLASSES));
    q_data.is_free   = (req_q.op == OP_FREE);
    q_data.null_addr = (req_q.block_addr == '0);
    q_data.pooled    = pooled;
    q_data.cls       = pooled ? k[CLASS_W-1:0] : '0;
    q_data.size      = size_eff;
    q_data.addr      = req_q.block_addr;
  end

  assign q_push = held;

endmodule

// ----- sv/fac_queue.sv -----
// Two-entry queue of classified requests between the front and back ends.
// Depends on fac_pkg.
module fac_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fac_pkg::fac_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output fac_pkg::fac_cmd_t pop_data,
  output logic              empty
);
  import fac_pkg::*;

  fac_cmd_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- sv/fac_back.sv -----
// Back end: per-class fill counters, the free block stack RAM, and the result
// register. Depends on fac_pkg and fac_ram.
module fac_back #(
  parameter int NUM_CLASSES = fac_pkg::NUM_CLASSES_DEF,
  parameter int STACK_DEPTH = fac_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  fac_pkg::fac_cmd_t q_data,
  output logic              q_pop,
  output logic              done,
  output fac_pkg::fac_rsp_t result
);
  import fac_pkg::*;

  localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int FW    = $clog2(STACK_DEPTH + 1);
  localparam int WORDS = NUM_CLASSES * STACK_DEPTH;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [FW-1:0]        fill [NUM_CLASSES];
  logic [CW-1:0]        idx;
  logic [FW-1:0]        fill_cur;
  logic [AW-1:0]        base;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic                 do_push;
  logic                 do_pop;
  logic [STATUS_W-1:0]  st;
  logic [SIZE_W-1:0]    bsize;
  logic [CLASS_W-1:0]   cls_out;
  logic [ADDR_BITS-1:0] ram_rdata;

  logic                 out_valid;
  logic                 out_hit;
  logic [STATUS_W-1:0]  out_status;
  logic [SIZE_W-1:0]    out_bsize;
  logic [CLASS_W-1:0]   out_cls;

  // Every queued item is taken at once; the back end never stalls.
  assign q_pop    = !q_empty;
  assign idx      = q_data.cls[CW-1:0];
  assign fill_cur = fill[idx];
  assign base     = AW'(AW'(idx) * AW'(STACK_DEPTH));
  assign waddr    = base + AW'(fill_cur);
  assign raddr    = base + AW'(fill_cur - FW'(1));

  always_comb begin
    do_push = 1'b0;
    do_pop  = 1'b0;
    st      = ST_NULL;
    bsize   = '0;
    cls_out = '0;
    if (q_data.is_free) begin
      if (q_data.null_addr) begin
        st = ST_NULL;
      end else if (!q_data.pooled) begin
        st = ST_RELEASE;
      end else begin
        cls_out = q_data.cls;
        if (fill_cur < FW'(STACK_DEPTH)) begin
          do_push = 1'b1;
          st      = ST_KEPT;
        end else begin
          st = ST_RELEASE;
        end
      end
    end else begin
      if (!q_data.pooled) begin
        st    = ST_BACK_OVER;
        bsize = q_data.size;
      end else begin
        cls_out = q_data.cls;
        if (fill_cur != '0) begin
          do_pop = 1'b1;
          st     = ST_HIT;
        end else begin
          st    = ST_BACK_ROUND;
          bsize = 32'd1 << q_data.cls;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        fill[i] <= '0;
      end
    end else if (q_pop) begin
      if (do_push) begin
        fill[idx] <= fill_cur + FW'(1);
      end else if (do_pop) begin
        fill[idx] <= fill_cur - FW'(1);
      end
    end
  end

  fac_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_stack_ram (
    .clk   (clk),
    .we    (q_pop && do_push),
    .waddr (waddr),
    .wdata (q_data.addr),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    out_hit    <= do_pop;
    out_status <= st;
    out_bsize  <= bsize;
    out_cls    <= cls_out;
  end

  assign done                = out_valid;
  assign result.status       = out_status;
  assign result.result_addr  = out_hit ? ram_rdata : '0;
  assign result.backing_size = out_bsize;
  assign result.size_class   = out_cls;

endmodule
